### src/vrap_pkg.sv
// Package for the video RAM access port.
// Holds the shared types, timing constants and the address remap function.
// No dependencies.
package vrap_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int ROW_BITS      = MEM_ADDR_BITS - 1;
    localparam int ROWS          = 1 << ROW_BITS;

    localparam logic [8:0]  LAST_LINE_525   = 9'(525 / 2 - 1);
    localparam logic [8:0]  LAST_LINE_625   = 9'(625 / 2 - 1);
    localparam logic [8:0]  VIS_LINES       = 9'd224;
    localparam logic [8:0]  VIS_LINES_OVER  = 9'd239;
    localparam logic [8:0]  FIRST_WR_LINE   = 9'd225;
    localparam logic [8:0]  FIRST_WR_OVER   = 9'd240;
    localparam logic [10:0] REFRESH_DOT     = 11'd1362;
    localparam logic [10:0] EARLY_DOT_LAST  = 11'd4;
    localparam logic [10:0] BUS_DOT         = 11'd6;
    localparam logic [7:0]  STEP_ONE        = 8'd1;
    localparam logic [7:0]  STEP_ROW        = 8'd32;
    localparam logic [7:0]  STEP_WIDE       = 8'd128;

    typedef enum logic [2:0] {
        CMD_MODE       = 3'd0,
        CMD_ADDR_LOW   = 3'd1,
        CMD_ADDR_HIGH  = 3'd2,
        CMD_WRITE_LOW  = 3'd3,
        CMD_WRITE_HIGH = 3'd4,
        CMD_READ_LOW   = 3'd5,
        CMD_READ_HIGH  = 3'd6
    } command_t;

    typedef enum logic [1:0] {
        REG_OVERSCAN  = 2'd0,
        REG_PAL       = 2'd1,
        REG_INTERLACE = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2,
        ST_FILL  = 2'd3
    } state_t;

    typedef struct packed {
        logic overscan_mode;
        logic pal_region;
        logic interlace_mode;
    } cfg_t;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic exec_fire;
        logic fill;
        logic clear_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        command_t    command;
        logic [7:0]  data_byte;
        logic [8:0]  scan_line;
        logic [10:0] scan_dot;
        logic        display_blanked;
        logic        odd_field;
        logic [7:0]  bus_open_value;
    } in_item_t;

    function automatic logic [MEM_ADDR_BITS-1:0] remap(
        input logic [MEM_ADDR_BITS-1:0] w,
        input logic [1:0]               mode
    );
        logic [MEM_ADDR_BITS-1:0] a;
        case (mode)
            2'd1:    a = {w[15:8], w[4:0], w[7:5]};
            2'd2:    a = {w[15:9], w[5:0], w[8:6]};
            2'd3:    a = {w[15:10], w[6:0], w[9:7]};
            default: a = w;
        endcase
        return a;
    endfunction

endpackage

### src/vrap_if.sv
// Handshake interfaces for the access and result channels.
// Depends on nothing; payload widths follow the access fields.
interface vrap_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  data_byte;
    logic [8:0]  scan_line;
    logic [10:0] scan_dot;
    logic        display_blanked;
    logic        odd_field;
    logic [7:0]  bus_open_value;

    modport source (
        output valid, command, data_byte, scan_line, scan_dot,
        output display_blanked, odd_field, bus_open_value,
        input  ready
    );
    modport sink (
        input  valid, command, data_byte, scan_line, scan_dot,
        input  display_blanked, odd_field, bus_open_value,
        output ready
    );
endinterface

interface vrap_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink (input valid, read_data, output ready);
endinterface

### src/vrap_ctrl.sv
// Controller of the video RAM access port: clear, idle, execute and fill.
// Depends on vrap_pkg.
module vrap_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  vrap_pkg::dp_status_t   status,
    output vrap_pkg::ctrl_cmd_t    cmd
);

    vrap_pkg::state_t state_reg;
    vrap_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vrap_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vrap_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = vrap_pkg::ST_IDLE;
                end
            end
            vrap_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vrap_pkg::ST_EXEC;
                end
            end
            vrap_pkg::ST_EXEC:
            begin
                if (!status.out_busy)
                begin
                    state_next = vrap_pkg::ST_FILL;
                end
            end
            vrap_pkg::ST_FILL:
            begin
                state_next = in_valid ? vrap_pkg::ST_EXEC : vrap_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vrap_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            vrap_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            vrap_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.accept   = in_valid;
            end
            vrap_pkg::ST_EXEC:
            begin
                cmd.exec_fire = !status.out_busy;
            end
            vrap_pkg::ST_FILL:
            begin
                cmd.in_ready = 1'b1;
                cmd.accept   = in_valid;
                cmd.fill     = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### src/vrap_dp.sv
// Datapath of the video RAM access port: address, prefetch, gating, memory.
// Depends on vrap_pkg; driven by vrap_ctrl.
module vrap_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vrap_pkg::ctrl_cmd_t   cmd,
    input  vrap_pkg::cfg_t        cfg,
    input  vrap_pkg::in_item_t    item,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [7:0]            read_data,
    output vrap_pkg::dp_status_t  status
);

    logic [15:0] mem [vrap_pkg::ROWS];

    vrap_pkg::in_item_t item_reg;
    logic [15:0] word_addr_reg, word_addr_next;
    logic [15:0] prefetch_reg;
    logic [7:0]  step_reg, step_next;
    logic        inc_high_reg, inc_high_next;
    logic [1:0]  remap_reg, remap_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  read_data_reg, read_data_next;
    logic [vrap_pkg::ROW_BITS-1:0] clear_idx_reg;
    logic        refill_reg;
    logic        read_ok_reg;
    logic [15:0] mem_rdata_reg;

    logic [15:0] addr_sel;
    logic [15:0] addr_mapped;
    logic [vrap_pkg::ROW_BITS-1:0] row;
    logic [8:0]  last_line;
    logic [8:0]  vis_line;
    logic [8:0]  first_line;
    logic        at_refresh;
    logic        read_ok;
    logic        write_ok;
    logic        use_bus;
    logic        is_write;
    logic        refill_req;
    logic        step_req;
    logic [7:0]  wr_byte;
    logic        mem_we;
    logic        mem_re;
    logic [1:0]  mem_be;
    logic [vrap_pkg::ROW_BITS-1:0] mem_addr;
    logic [15:0] mem_wdata;

    always_comb
    begin
        case (item_reg.command)
            vrap_pkg::CMD_ADDR_LOW:  addr_sel = {word_addr_reg[15:8], item_reg.data_byte};
            vrap_pkg::CMD_ADDR_HIGH: addr_sel = {item_reg.data_byte, word_addr_reg[7:0]};
            default:                 addr_sel = word_addr_reg;
        endcase
    end

    assign addr_mapped = vrap_pkg::remap(addr_sel, remap_reg);
    assign row         = addr_mapped[vrap_pkg::ROW_BITS-1:0];

    assign last_line  = (cfg.pal_region ? vrap_pkg::LAST_LINE_625 : vrap_pkg::LAST_LINE_525)
                        + {8'd0, cfg.interlace_mode && !item_reg.odd_field};
    assign vis_line   = cfg.overscan_mode ? vrap_pkg::VIS_LINES_OVER : vrap_pkg::VIS_LINES;
    assign first_line = cfg.overscan_mode ? vrap_pkg::FIRST_WR_OVER : vrap_pkg::FIRST_WR_LINE;
    assign at_refresh = item_reg.scan_dot == vrap_pkg::REFRESH_DOT;

    assign read_ok = item_reg.display_blanked
                     || !((item_reg.scan_line == last_line && at_refresh)
                          || item_reg.scan_line < vis_line
                          || (item_reg.scan_line == vis_line && !at_refresh));

    always_comb
    begin
        write_ok = 1'b0;
        use_bus  = 1'b0;
        if (item_reg.display_blanked)
        begin
            write_ok = 1'b1;
        end
        else if (item_reg.scan_line == 9'd0)
        begin
            if (item_reg.scan_dot <= vrap_pkg::EARLY_DOT_LAST)
            begin
                write_ok = 1'b1;
            end
            else if (item_reg.scan_dot == vrap_pkg::BUS_DOT)
            begin
                write_ok = 1'b1;
                use_bus  = 1'b1;
            end
        end
        else if (item_reg.scan_line < first_line)
        begin
            write_ok = 1'b0;
        end
        else if (item_reg.scan_line == first_line)
        begin
            write_ok = item_reg.scan_dot > vrap_pkg::EARLY_DOT_LAST;
        end
        else
        begin
            write_ok = 1'b1;
        end
    end

    always_comb
    begin
        is_write   = 1'b0;
        refill_req = 1'b0;
        step_req   = 1'b0;
        case (item_reg.command)
            vrap_pkg::CMD_ADDR_LOW, vrap_pkg::CMD_ADDR_HIGH:
            begin
                refill_req = 1'b1;
            end
            vrap_pkg::CMD_WRITE_LOW:
            begin
                is_write = 1'b1;
                step_req = !inc_high_reg;
            end
            vrap_pkg::CMD_WRITE_HIGH:
            begin
                is_write = 1'b1;
                step_req = inc_high_reg;
            end
            vrap_pkg::CMD_READ_LOW:
            begin
                refill_req = !inc_high_reg;
                step_req   = !inc_high_reg;
            end
            vrap_pkg::CMD_READ_HIGH:
            begin
                refill_req = inc_high_reg;
                step_req   = inc_high_reg;
            end
            default:
            begin
                is_write = 1'b0;
            end
        endcase
    end

    assign wr_byte   = use_bus ? item_reg.bus_open_value : item_reg.data_byte;
    assign mem_we    = cmd.clear_en || (cmd.exec_fire && is_write && write_ok);
    assign mem_re    = cmd.exec_fire && refill_req;
    assign mem_addr  = cmd.clear_en ? clear_idx_reg : row;
    assign mem_wdata = cmd.clear_en ? 16'd0 : {wr_byte, wr_byte};
    assign mem_be    = cmd.clear_en ? 2'b11
                     : (item_reg.command == vrap_pkg::CMD_WRITE_HIGH ? 2'b10 : 2'b01);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            if (mem_be[0])
            begin
                mem[mem_addr][7:0] <= mem_wdata[7:0];
            end
            if (mem_be[1])
            begin
                mem[mem_addr][15:8] <= mem_wdata[15:8];
            end
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[row];
        end
    end

    always_comb
    begin
        word_addr_next = word_addr_reg;
        step_next      = step_reg;
        inc_high_next  = inc_high_reg;
        remap_next     = remap_reg;
        read_data_next = read_data_reg;
        if (cmd.exec_fire)
        begin
            word_addr_next = step_req ? word_addr_reg + {8'd0, step_reg} : addr_sel;
            case (item_reg.command)
                vrap_pkg::CMD_MODE:
                begin
                    inc_high_next = item_reg.data_byte[7];
                    remap_next    = item_reg.data_byte[3:2];
                    case (item_reg.data_byte[1:0])
                        2'd0:    step_next = vrap_pkg::STEP_ONE;
                        2'd1:    step_next = vrap_pkg::STEP_ROW;
                        default: step_next = vrap_pkg::STEP_WIDE;
                    endcase
                end
                default:
                begin
                    inc_high_next = inc_high_reg;
                end
            endcase
            case (item_reg.command)
                vrap_pkg::CMD_READ_LOW:  read_data_next = prefetch_reg[7:0];
                vrap_pkg::CMD_READ_HIGH: read_data_next = prefetch_reg[15:8];
                default:                 read_data_next = 8'd0;
            endcase
        end
    end

    assign out_valid_next = cmd.exec_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        read_data_reg <= read_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_addr_reg <= '0;
            prefetch_reg  <= '0;
            step_reg      <= vrap_pkg::STEP_ONE;
            inc_high_reg  <= 1'b0;
            remap_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
            clear_idx_reg <= '0;
            refill_reg    <= 1'b0;
            read_ok_reg   <= 1'b0;
        end
        else
        begin
            word_addr_reg <= word_addr_next;
            step_reg      <= step_next;
            inc_high_reg  <= inc_high_next;
            remap_reg     <= remap_next;
            out_valid_reg <= out_valid_next;
            if (cmd.clear_en)
            begin
                clear_idx_reg <= clear_idx_reg + 1'b1;
            end
            if (cmd.exec_fire)
            begin
                refill_reg  <= refill_req;
                read_ok_reg <= read_ok;
            end
            if (cmd.fill && refill_reg)
            begin
                prefetch_reg <= read_ok_reg ? mem_rdata_reg : 16'd0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign read_data         = read_data_reg;
    assign status.out_busy   = out_valid_reg && !out_ready;
    assign status.clear_last = cmd.clear_en && (&clear_idx_reg);

    a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.exec_fire))
        else $error("result raised without an executed transaction");

    a_prefetch_on_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(prefetch_reg) |-> $past(cmd.fill && refill_reg))
        else $error("prefetch changed outside a refill");

    a_addr_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |=> $stable(word_addr_reg))
        else $error("word address moved during memory clear");

endmodule

### src/video_ram_access_port_unit.sv
// Top level of the video RAM access port: APB registers, controller, datapath.
// Depends on vrap_pkg, vrap_if, vrap_ctrl and vrap_dp.
//
// Usage:
//   in_ch carries one CPU bus transaction per item (mode, address byte, data
//   byte write or prefetch byte read, plus the scan position for gating).
//   out_ch returns one result per transaction: the prefetch byte for reads,
//   zero otherwise.
//   The APB port holds overscan, region and interlace flags at byte
//   addresses 0, 4 and 8; write them only while no transaction is in flight.
// Sequence:
//   A transaction is executed (address, gating, memory access) and then, in
//   fill, the prefetch word is loaded from the registered memory read. The
//   next transaction is taken in fill, so the port takes a new transaction
//   before the last is through; execute waits while the result is stalled.
//   The result is registered when execute fires.
// Reset and stalls:
//   After reset the memory is cleared one 16-bit row per cycle, all 32768 rows,
//   with in_ch.ready low; APB writes are taken throughout.
//   A result held by a stalled receiver sits in the output register; one
//   further transaction is taken and waits in execute until it drains.
module video_ram_access_port_unit (
    input  logic              clk,
    input  logic              rst_n,
    vrap_in_if.sink           in_ch,
    vrap_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    vrap_pkg::cfg_t       cfg_reg;
    vrap_pkg::cfg_t       cfg_next;
    vrap_pkg::ctrl_cmd_t  cmd;
    vrap_pkg::dp_status_t status;
    vrap_pkg::in_item_t   item;
    vrap_pkg::reg_index_t reg_index;
    logic                 cfg_write;

    assign reg_index = vrap_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index)
                vrap_pkg::REG_OVERSCAN:  cfg_next.overscan_mode  = pwdata[0];
                vrap_pkg::REG_PAL:       cfg_next.pal_region     = pwdata[0];
                vrap_pkg::REG_INTERLACE: cfg_next.interlace_mode = pwdata[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            vrap_pkg::REG_OVERSCAN:  prdata = {31'd0, cfg_reg.overscan_mode};
            vrap_pkg::REG_PAL:       prdata = {31'd0, cfg_reg.pal_region};
            vrap_pkg::REG_INTERLACE: prdata = {31'd0, cfg_reg.interlace_mode};
            default:                 prdata = 32'd0;
        endcase
    end

    assign item.command         = vrap_pkg::command_t'(in_ch.command);
    assign item.data_byte       = in_ch.data_byte;
    assign item.scan_line       = in_ch.scan_line;
    assign item.scan_dot        = in_ch.scan_dot;
    assign item.display_blanked = in_ch.display_blanked;
    assign item.odd_field       = in_ch.odd_field;
    assign item.bus_open_value  = in_ch.bus_open_value;

    assign in_ch.ready = cmd.in_ready;

    vrap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .status   (status),
        .cmd      (cmd)
    );

    vrap_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .item      (item),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .read_data (out_ch.read_data),
        .status    (status)
    );

endmodule

### tb/video_ram_access_port_unit_tb.sv
// Testbench for video_ram_access_port_unit: directed table, then random bursts and single accesses per setting.
// Results are checked against an in-bench model of the port, memory and scan gating.
// Depends on vrap_pkg, vrap_if and the RTL of the port.
`timescale 1ns / 100ps

module video_ram_access_port_unit_tb;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int IDLE_LIMIT = 200000;
    localparam int PHASE_ACCESSES = 300;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  data_byte;
        logic [8:0]  scan_line;
        logic [10:0] scan_dot;
        logic        display_blanked;
        logic        odd_field;
        logic [7:0]  bus_open_value;
    } access_t;

    typedef struct packed {
        access_t    acc;
        logic       pinned;
        logic [7:0] want;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    vrap_in_if  in_ch ();
    vrap_out_if out_ch ();

    video_ram_access_port_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    logic [7:0]  vram [0:65535];
    logic [15:0] word_addr;
    logic [15:0] prefetch;
    logic [7:0]  addr_step;
    logic        step_on_high;
    logic [1:0]  remap_mode;
    vrap_pkg::cfg_t cfg;

    logic [7:0]  pending_read_data [$];
    table_row_t  directed_rows [$];
    logic        pin_on;
    logic [7:0]  pin_value;
    bit          calm;
    int          mismatches;
    int          idle_cycles;
    int          accesses_sent;

    function automatic logic [15:0] byte_addr();
        logic [15:0] a;
        a = word_addr;
        case (remap_mode)
            2'd1: a = (word_addr & 16'hff00) | ((word_addr & 16'h001f) << 3)
                      | ((word_addr >> 5) & 16'h0007);
            2'd2: a = (word_addr & 16'hfe00) | ((word_addr & 16'h003f) << 3)
                      | ((word_addr >> 6) & 16'h0007);
            2'd3: a = (word_addr & 16'hfc00) | ((word_addr & 16'h007f) << 3)
                      | ((word_addr >> 7) & 16'h0007);
            default: a = word_addr;
        endcase
        return a << 1;
    endfunction

    function automatic logic [7:0] gated_fetch(input logic [15:0] addr, input access_t acc);
        int last_line;
        int vis;
        logic [7:0] v;
        v = vram[addr];
        if (acc.display_blanked)
            return v;
        last_line = (cfg.pal_region ? 625 : 525) / 2 - 1;
        if (cfg.interlace_mode && !acc.odd_field)
            last_line++;
        vis = cfg.overscan_mode ? 239 : 224;
        if (acc.scan_line == last_line && acc.scan_dot == 1362)
            return 8'h00;
        if (acc.scan_line < vis)
            return 8'h00;
        if (acc.scan_line == vis)
            return (acc.scan_dot == 1362) ? v : 8'h00;
        return v;
    endfunction

    function automatic void gated_store(input logic [15:0] addr, input access_t acc);
        int first;
        logic doit;
        logic [7:0] val;
        first = cfg.overscan_mode ? 240 : 225;
        doit = 1'b0;
        val = acc.data_byte;
        if (acc.display_blanked)
            doit = 1'b1;
        else if (acc.scan_line == 0)
        begin
            if (acc.scan_dot <= 4)
                doit = 1'b1;
            else if (acc.scan_dot == 6)
            begin
                doit = 1'b1;
                val = acc.bus_open_value;
            end
        end
        else if (acc.scan_line < first)
            doit = 1'b0;
        else if (acc.scan_line == first)
            doit = acc.scan_dot > 4;
        else
            doit = 1'b1;
        if (doit)
            vram[addr] = val;
    endfunction

    function automatic void refill(input logic [15:0] addr, input access_t acc);
        prefetch = {gated_fetch(addr + 16'd1, acc), gated_fetch(addr, acc)};
    endfunction

    function automatic logic [7:0] apply_access(input access_t acc);
        logic [7:0] rd;
        rd = 8'h00;
        case (acc.command)
            vrap_pkg::CMD_MODE:
            begin
                step_on_high = acc.data_byte[7];
                remap_mode = acc.data_byte[3:2];
                case (acc.data_byte[1:0])
                    2'd0: addr_step = 8'd1;
                    2'd1: addr_step = 8'd32;
                    default: addr_step = 8'd128;
                endcase
            end
            vrap_pkg::CMD_ADDR_LOW:
            begin
                word_addr[7:0] = acc.data_byte;
                refill(byte_addr(), acc);
            end
            vrap_pkg::CMD_ADDR_HIGH:
            begin
                word_addr[15:8] = acc.data_byte;
                refill(byte_addr(), acc);
            end
            vrap_pkg::CMD_WRITE_LOW:
            begin
                gated_store(byte_addr(), acc);
                if (!step_on_high)
                    word_addr += addr_step;
            end
            vrap_pkg::CMD_WRITE_HIGH:
            begin
                gated_store(byte_addr() + 16'd1, acc);
                if (step_on_high)
                    word_addr += addr_step;
            end
            vrap_pkg::CMD_READ_LOW:
            begin
                rd = prefetch[7:0];
                if (!step_on_high)
                begin
                    refill(byte_addr() & 16'hfffe, acc);
                    word_addr += addr_step;
                end
            end
            vrap_pkg::CMD_READ_HIGH:
            begin
                rd = prefetch[15:8];
                if (step_on_high)
                begin
                    refill(byte_addr() & 16'hfffe, acc);
                    word_addr += addr_step;
                end
            end
            default: ;
        endcase
        return rd;
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected read_data %02h, got %02h", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin : monitor
        access_t seen;
        logic [7:0] want;
        logic [7:0] model_rd;
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                moved = 1'b1;
                if (pending_read_data.size() == 0)
                    note_mismatch("result with nothing pending", 8'h00, out_ch.read_data);
                else
                begin
                    want = pending_read_data.pop_front();
                    if (want !== out_ch.read_data)
                        note_mismatch("read_data", want, out_ch.read_data);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                moved = 1'b1;
                seen.command = in_ch.command;
                seen.data_byte = in_ch.data_byte;
                seen.scan_line = in_ch.scan_line;
                seen.scan_dot = in_ch.scan_dot;
                seen.display_blanked = in_ch.display_blanked;
                seen.odd_field = in_ch.odd_field;
                seen.bus_open_value = in_ch.bus_open_value;
                model_rd = apply_access(seen);
                pending_read_data.push_back(pin_on ? pin_value : model_rd);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("video_ram_access_port_unit_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 8));
    endfunction

    initial
    begin : receiver
        int stall;
        out_ch.ready = 1'b0;
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    task automatic send_access(input access_t acc, input logic pinned, input logic [7:0] want);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.command = acc.command;
        in_ch.data_byte = acc.data_byte;
        in_ch.scan_line = acc.scan_line;
        in_ch.scan_dot = acc.scan_dot;
        in_ch.display_blanked = acc.display_blanked;
        in_ch.odd_field = acc.odd_field;
        in_ch.bus_open_value = acc.bus_open_value;
        pin_on = pinned;
        pin_value = want;
        in_ch.valid = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        accesses_sent++;
    endtask

    task automatic apb_write(input vrap_pkg::reg_index_t idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            vrap_pkg::REG_OVERSCAN: cfg.overscan_mode = value[0];
            vrap_pkg::REG_PAL: cfg.pal_region = value[0];
            vrap_pkg::REG_INTERLACE: cfg.interlace_mode = value[0];
            default: ;
        endcase
    endtask

    task automatic write_settings(input vrap_pkg::cfg_t setting);
        apb_write(vrap_pkg::REG_OVERSCAN, {31'd0, setting.overscan_mode});
        apb_write(vrap_pkg::REG_PAL, {31'd0, setting.pal_region});
        apb_write(vrap_pkg::REG_INTERLACE, {31'd0, setting.interlace_mode});
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending_read_data.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic add_row(input logic [2:0] command, input logic [7:0] data, input int line,
                           input int dot, input bit blanked, input bit odd,
                           input logic [7:0] bus, input bit pinned, input logic [7:0] want);
        table_row_t r;
        r.acc = {command, data, 9'(line), 11'(dot), blanked, odd, bus};
        r.pinned = pinned;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    function automatic access_t random_spot(input logic [2:0] command, input logic [7:0] data);
        access_t acc;
        acc.command = command;
        acc.data_byte = data;
        acc.odd_field = 1'($urandom_range(0, 1));
        acc.bus_open_value = 8'($urandom_range(0, 255));
        acc.display_blanked = ($urandom_range(0, 9) < 4);
        case ($urandom_range(0, 13))
            0: acc.scan_line = 9'd0;
            1: acc.scan_line = 9'd223;
            2: acc.scan_line = 9'd224;
            3: acc.scan_line = 9'd225;
            4: acc.scan_line = 9'd238;
            5: acc.scan_line = 9'd239;
            6: acc.scan_line = 9'd240;
            7: acc.scan_line = 9'd261;
            8: acc.scan_line = 9'd262;
            9: acc.scan_line = 9'd311;
            10: acc.scan_line = 9'd312;
            11: acc.scan_line = 9'($urandom_range(0, 312));
            12: acc.scan_line = 9'($urandom_range(0, 511));
            default: acc.scan_line = 9'($urandom_range(226, 310));
        endcase
        case ($urandom_range(0, 9))
            0, 1: acc.scan_dot = 11'($urandom_range(0, 6));
            2: acc.scan_dot = 11'($urandom_range(1361, 1363));
            3: acc.scan_dot = 11'd1362;
            4: acc.scan_dot = 11'($urandom_range(0, 2047));
            default: acc.scan_dot = 11'($urandom_range(0, 1363));
        endcase
        return acc;
    endfunction

    function automatic logic [7:0] pick_high_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'h7f;
            2: return 8'h80;
            3: return 8'hff;
            4: return 8'h3c;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_burst();
        logic [7:0] lo;
        logic [7:0] hi;
        int n;
        lo = 8'($urandom_range(0, 255));
        hi = pick_high_byte();
        n = $urandom_range(1, 6);
        send_access(random_spot(vrap_pkg::CMD_MODE, 8'($urandom_range(0, 255))), 1'b0, 8'h00);
        send_access(random_spot(vrap_pkg::CMD_ADDR_HIGH, hi), 1'b0, 8'h00);
        send_access(random_spot(vrap_pkg::CMD_ADDR_LOW, lo), 1'b0, 8'h00);
        repeat (n)
            send_access(random_spot($urandom_range(0, 1) ? vrap_pkg::CMD_WRITE_LOW
                                                         : vrap_pkg::CMD_WRITE_HIGH,
                                    8'($urandom_range(0, 255))), 1'b0, 8'h00);
        send_access(random_spot(vrap_pkg::CMD_ADDR_HIGH, hi), 1'b0, 8'h00);
        send_access(random_spot(vrap_pkg::CMD_ADDR_LOW, lo), 1'b0, 8'h00);
        repeat (2 * n + 1)
            send_access(random_spot($urandom_range(0, 1) ? vrap_pkg::CMD_READ_LOW
                                                         : vrap_pkg::CMD_READ_HIGH,
                                    8'($urandom_range(0, 255))), 1'b0, 8'h00);
    endtask

    initial
    begin : stimulus
        logic [2:0] settings [0:5];
        int phase_end;
        settings = '{3'b111, 3'b100, 3'b011, 3'b010, 3'b001, 3'b000};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.command = vrap_pkg::CMD_MODE;
        in_ch.data_byte = '0;
        in_ch.scan_line = '0;
        in_ch.scan_dot = '0;
        in_ch.display_blanked = 1'b0;
        in_ch.odd_field = 1'b0;
        in_ch.bus_open_value = '0;
        pin_on = 1'b0;
        pin_value = '0;
        calm = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        accesses_sent = 0;
        for (int i = 0; i < 65536; i++)
            vram[i] = 8'h00;
        word_addr = '0;
        prefetch = '0;
        addr_step = 8'd1;
        step_on_high = 1'b0;
        remap_mode = 2'd0;
        cfg = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        write_settings(vrap_pkg::cfg_t'(3'b000));

        add_row(vrap_pkg::CMD_READ_HIGH,  8'h00,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_MODE,       8'h00,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_ADDR_HIGH,  8'hff,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_ADDR_LOW,   8'hff,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_WRITE_LOW,  8'hff,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_MODE,       8'h80,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_ADDR_HIGH,  8'h7f,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_ADDR_LOW,   8'hff,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_READ_LOW,   8'h00,   0,    0, 1, 0, 8'h00, 0, 8'h00);
        add_row(vrap_pkg::CMD_WRITE_HIGH, 8'h5a,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_MODE,       8'h01,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_ADDR_LOW,   8'h00,   0,    0, 0, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_WRITE_LOW,  8'h11,   0,    4, 0, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_WRITE_LOW,  8'h22,   0,    5, 0, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_WRITE_LOW,  8'h33,   0,    6, 0, 0, 8'h44, 1, 8'h00);
        add_row(vrap_pkg::CMD_WRITE_LOW,  8'h55, 224,  100, 0, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_WRITE_LOW,  8'h66, 225,    4, 0, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_WRITE_LOW,  8'h77, 225,    5, 0, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_MODE,       8'h8e,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_ADDR_LOW,   8'h20, 224, 1362, 0, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_READ_HIGH,  8'h00, 261, 1362, 0, 1, 8'h00, 0, 8'h00);
        add_row(vrap_pkg::CMD_READ_HIGH,  8'h00, 262, 1362, 0, 0, 8'h00, 0, 8'h00);
        add_row(vrap_pkg::CMD_MODE,       8'h07,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_READ_LOW,   8'h00, 300, 2047, 0, 0, 8'h00, 0, 8'h00);
        add_row(CMD_UNUSED,               8'hff, 312, 1363, 0, 1, 8'hff, 1, 8'h00);
        add_row(vrap_pkg::CMD_MODE,       8'h0b,   0,    0, 1, 0, 8'h00, 1, 8'h00);
        add_row(vrap_pkg::CMD_READ_LOW,   8'h00,   0,    0, 1, 0, 8'h00, 0, 8'h00);

        foreach (directed_rows[i])
            send_access(directed_rows[i].acc, directed_rows[i].pinned, directed_rows[i].want);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_settings(vrap_pkg::cfg_t'(settings[p]));
            phase_end = accesses_sent + PHASE_ACCESSES;
            while (accesses_sent < phase_end)
            begin
                if ($urandom_range(0, 15) == 0)
                    calm = !calm;
                if ($urandom_range(0, 9) < 7)
                    run_burst();
                else
                    send_access(random_spot(3'($urandom_range(0, 7)),
                                            8'($urandom_range(0, 255))),
                                1'b0, 8'h00);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_read_data.size() == 0)
            $display("video_ram_access_port_unit_tb: done, clean");
        else
            $display("video_ram_access_port_unit_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
src/vrap_pkg.sv
src/vrap_if.sv
src/vrap_ctrl.sv
src/vrap_dp.sv
src/video_ram_access_port_unit.sv
tb/video_ram_access_port_unit_tb.sv
